/* rtl/hill_pkg.sv */
// ----------------------------------------------------------------------------
// hill_pkg: shared types, constants and helpers
// Word types, register indexes and the small modulo-26 arithmetic used by
// the key derivation and the decrypt datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package hill_pkg;

  localparam int LetterW   = 5;
  localparam int Alpha     = 26;
  localparam int AlphaSq   = Alpha * Alpha;
  localparam int PadLetter = 25;

  // floor(2^16 / 26); the quotient estimate is at most one low for 11-bit values.
  localparam int RecipAlpha = 65536 / Alpha;

  // Inverse of the known plaintext matrix [[19,7],[7,4]] mod 26.
  localparam int InvP00 = 4;
  localparam int InvP01 = 19;
  localparam int InvP10 = 19;
  localparam int InvP11 = 19;

  // Cycles the key pipeline needs after a register change.
  localparam int KeySettle = 3;

  typedef logic [LetterW-1:0] letter_t;

  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t RegThFirst  = 2'd0;
  localparam cfg_index_t RegThSecond = 2'd1;
  localparam cfg_index_t RegHeFirst  = 2'd2;
  localparam cfg_index_t RegHeSecond = 2'd3;

  typedef struct packed {
    letter_t cipher_first;
    letter_t cipher_second;
    logic    second_present;
  } hill_in_t;

  typedef struct packed {
    letter_t plain_first;
    letter_t plain_second;
    logic    key_error;
  } hill_out_t;

  // Inverse key handed from the key unit to the datapath.
  typedef struct packed {
    logic    settling;
    letter_t ia;
    letter_t ib;
    letter_t ic;
    letter_t id;
    logic    key_error;
  } hill_key_t;

  // Values 26..31 act as the letter minus 26.
  function automatic letter_t letter(input logic [LetterW-1:0] v);
    letter_t r;
    if (v >= LetterW'(Alpha)) begin
      r = v - LetterW'(Alpha);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // x mod 26 for x below 2048: reciprocal multiply, then one correction.
  function automatic letter_t mod26(input logic [10:0] x);
    logic [22:0] prod;
    logic [6:0]  q;
    logic [10:0] r;
    prod = 23'(x) * 23'(RecipAlpha);
    q    = prod[22:16];
    r    = x - 11'(q) * 11'(Alpha);
    if (r >= 11'(Alpha)) begin
      r = r - 11'(Alpha);
    end
    return r[LetterW-1:0];
  endfunction

  // Multiplicative inverse mod 26, zero when none exists.
  function automatic letter_t inv26(input letter_t d);
    letter_t r;
    case (d)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // Additive inverse mod 26 of a reduced letter.
  function automatic letter_t neg26(input letter_t v);
    letter_t r;
    if (v == '0) begin
      r = '0;
    end else begin
      r = LetterW'(Alpha) - v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/hill_key_unit.sv */
// ----------------------------------------------------------------------------
// hill_key_unit: key registers and inverse key derivation
// Holds the four known-pair cipher letters and derives the inverse key
// matrix through three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module hill_key_unit (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  input  wire hill_pkg::cfg_index_t cfg_index,
  input  wire hill_pkg::letter_t  cfg_data,
  output hill_pkg::hill_key_t     key
);
  import hill_pkg::*;

  letter_t th_first, th_second, he_first, he_second;
  logic [1:0] busy;

  letter_t ka, kb, kc, kd;
  letter_t ka2, kb2, kc2, kd2, dinv;
  letter_t det;
  letter_t ia, ib, ic, id;
  logic    key_error;

  logic cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      th_first  <= '0;
      th_second <= '0;
      he_first  <= '0;
      he_second <= '0;
      busy      <= 2'(KeySettle);
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          RegThFirst:  th_first  <= cfg_data;
          RegThSecond: th_second <= cfg_data;
          RegHeFirst:  he_first  <= cfg_data;
          RegHeSecond: he_second <= cfg_data;
        endcase
        busy <= 2'(KeySettle);
      end else if (busy != '0) begin
        busy <= busy - 2'd1;
      end
    end
  end

  // Stage 1: key matrix K = C * inv(P).
  always_ff @(posedge clk) begin
    ka <= mod26(11'(letter(th_first)) * 11'(InvP00) + 11'(letter(he_first)) * 11'(InvP10));
    kb <= mod26(11'(letter(th_first)) * 11'(InvP01) + 11'(letter(he_first)) * 11'(InvP11));
    kc <= mod26(11'(letter(th_second)) * 11'(InvP00) + 11'(letter(he_second)) * 11'(InvP10));
    kd <= mod26(11'(letter(th_second)) * 11'(InvP01) + 11'(letter(he_second)) * 11'(InvP11));
  end

  // Stage 2: determinant and its inverse.
  assign det = mod26(11'(ka) * 11'(kd) + 11'(AlphaSq) - 11'(kb) * 11'(kc));

  always_ff @(posedge clk) begin
    ka2  <= ka;
    kb2  <= kb;
    kc2  <= kc;
    kd2  <= kd;
    dinv <= inv26(det);
  end

  // Stage 3: inverse key as adjugate times inverse determinant.
  always_ff @(posedge clk) begin
    ia        <= mod26(11'(kd2) * 11'(dinv));
    ib        <= mod26(11'(neg26(kb2)) * 11'(dinv));
    ic        <= mod26(11'(neg26(kc2)) * 11'(dinv));
    id        <= mod26(11'(ka2) * 11'(dinv));
    key_error <= (dinv == '0);
  end

  assign key.settling  = (busy != '0);
  assign key.ia        = ia;
  assign key.ib        = ib;
  assign key.ic        = ic;
  assign key.id        = id;
  assign key.key_error = key_error;

endmodule

`default_nettype wire

/* rtl/hill_datapath.sv */
// ----------------------------------------------------------------------------
// hill_datapath: pair decrypt pipeline
// Input register, one matrix-vector product mod 26, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hill_datapath (
  input  wire                   clk,
  input  wire                   rst,
  input  wire hill_pkg::hill_key_t key,
  input  wire                   cipher_valid,
  output logic                  cipher_ready,
  input  wire hill_pkg::hill_in_t cipher,
  output logic                  plain_valid,
  input  wire                   plain_ready,
  output hill_pkg::hill_out_t   plain
);
  import hill_pkg::*;

  logic      a_valid;
  letter_t   a_c1, a_c2;
  logic      a_ready, b_ready, accept;
  hill_out_t result;

  assign b_ready      = !plain_valid || plain_ready;
  assign a_ready      = !a_valid || b_ready;
  assign cipher_ready = a_ready && !key.settling;
  assign accept       = cipher_valid && cipher_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid     <= 1'b0;
      plain_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= accept;
      end
      if (b_ready) begin
        plain_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_c1 <= letter(cipher.cipher_first);
      if (cipher.second_present) begin
        a_c2 <= letter(cipher.cipher_second);
      end else begin
        a_c2 <= LetterW'(PadLetter);
      end
    end
  end

  always_comb begin
    if (key.key_error) begin
      result.plain_first  = '0;
      result.plain_second = '0;
      result.key_error    = 1'b1;
    end else begin
      result.plain_first  = mod26(11'(key.ia) * 11'(a_c1) + 11'(key.ib) * 11'(a_c2));
      result.plain_second = mod26(11'(key.ic) * 11'(a_c1) + 11'(key.id) * 11'(a_c2));
      result.key_error    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && b_ready) begin
      plain <= result;
    end
  end

endmodule

`default_nettype wire

/* rtl/hill_2x2_known_plaintext_decrypt.sv */
// ----------------------------------------------------------------------------
// hill_2x2_known_plaintext_decrypt: 2x2 Hill cipher decryptor
// Derives the key from the cipher letters of the known pairs TH and HE,
// inverts it modulo 26 and decrypts one letter pair per word.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Handshake                 Word
//   cipher   in   cipher_valid/cipher_ready hill_in_t  (cipher pair)
//   plain    out  plain_valid/plain_ready   hill_out_t (plain pair, key_error)
//   cfg      in   cfg_valid/cfg_ready       cfg_index + cfg_data (known letters)
//
// One cipher word is accepted per cycle unless the key settles or plain
// stalls; its plain word passes the input register and the result register.
// A waiting result lets one more word into the input register, then the
// input holds; back-pressure on plain reaches cipher_ready combinationally.
// Reset is synchronous and clears the four key registers to zero. After reset
// and after every configuration write, cipher_ready stays low while the
// three-stage key pipeline settles.
`default_nettype none

module hill_2x2_known_plaintext_decrypt (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       cipher_valid,
  output logic                      cipher_ready,
  input  wire hill_pkg::hill_in_t   cipher,
  output logic                      plain_valid,
  input  wire                       plain_ready,
  output hill_pkg::hill_out_t       plain,
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire hill_pkg::cfg_index_t cfg_index,
  input  wire hill_pkg::letter_t    cfg_data
);
  import hill_pkg::*;

  // Inverse key and the settling flag from the key unit.
  hill_key_t key;

  // The key unit recomputes the inverse key continuously from the stored
  // letters; only its settling window gates the datapath.
  hill_key_unit u_key (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key)
  );

  // The datapath multiplies each pair by the inverse key modulo 26 and
  // forces zeros with key_error when the key is singular.
  hill_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .key          (key),
    .cipher_valid (cipher_valid),
    .cipher_ready (cipher_ready),
    .cipher       (cipher),
    .plain_valid  (plain_valid),
    .plain_ready  (plain_ready),
    .plain        (plain)
  );

endmodule

`default_nettype wire

/* rtl/hill_checker.sv */
// ----------------------------------------------------------------------------
// hill_checker: port-level assertions
// Watches the top level's ports and is bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

module hill_checker (
  input wire                       clk,
  input wire                       rst,
  input wire                       cipher_valid,
  input wire                       cipher_ready,
  input wire hill_pkg::hill_in_t   cipher,
  input wire                       plain_valid,
  input wire                       plain_ready,
  input wire hill_pkg::hill_out_t  plain,
  input wire                       cfg_valid,
  input wire                       cfg_ready,
  input wire hill_pkg::cfg_index_t cfg_index,
  input wire hill_pkg::letter_t    cfg_data
);
  import hill_pkg::*;

  // A stalled result holds.
  a_plain_hold: assert property (@(posedge clk) disable iff (rst)
    plain_valid && !plain_ready |=> plain_valid && $stable(plain))
    else $error("plain word changed while stalled");

  // A singular key gives zero letters.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    plain_valid && plain.key_error |-> plain.plain_first == '0 && plain.plain_second == '0)
    else $error("key_error with nonzero letters");

  // Results are reduced letters.
  a_range: assert property (@(posedge clk) disable iff (rst)
    plain_valid |-> plain.plain_first < LetterW'(Alpha) && plain.plain_second < LetterW'(Alpha))
    else $error("plain letter out of range");

  // The key pipeline holds off input after a key change or reset.
  a_settle: assert property (@(posedge clk)
    rst || (cfg_valid && cfg_ready) |=> !cipher_ready)
    else $error("cipher accepted while key settling");

endmodule

bind hill_2x2_known_plaintext_decrypt hill_checker u_hill_checker (.*);

`default_nettype wire
